// ----- sv/assert_macros.svh -----
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent in a cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ggc_pkg.sv -----
// types and constants of the greedy graph coloring block
// no dependencies
`default_nettype none

package ggc_pkg;

  localparam int ROW_W            = 32;
  localparam int COLOR_W          = 5;
  localparam int NUM_COLORS       = 32;
  localparam int COUNT_W          = 6;
  localparam int MAX_VERTICES_DEF = 32;

  typedef struct packed {
    logic [ROW_W-1:0] adjacency_row;
    logic             last_row;
  } item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] vertex_color;
    logic [COUNT_W-1:0] colors_used;
    logic               graph_done;
  } result_t;

  // bits whose color index has bit b set, for one-hot to binary
  function automatic logic [NUM_COLORS-1:0] index_bit_mask(input int b);
    logic [NUM_COLORS-1:0] m;
    m = '0;
    for (int i = 0; i < NUM_COLORS; i++) begin
      m[i] = ((i >> b) & 1) != 0;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- sv/greedy_graph_coloring.sv -----
// Greedy first-fit graph coloring, top level. Depends on ggc_pkg, ggc_lane, ggc_merge.
// One adjacency row is taken per cycle while item_ready is high; its result appears
// in the output register in the next cycle. All lanes decode the stored colors of
// earlier neighbors at once and the merge stage picks the lowest free color in the
// same cycle, so that lane-and-merge path into the color store sets this rate.
// The output register is one deep: while a result waits, item_ready is low. The
// color store needs no clearing after reset; only colors of earlier vertices of the
// current graph are read.
`default_nettype none

module greedy_graph_coloring #(
  parameter int MAX_VERTICES = ggc_pkg::MAX_VERTICES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire ggc_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output ggc_pkg::result_t      result
);
  import ggc_pkg::*;

  localparam int IDX_W  = $clog2(MAX_VERTICES);
  localparam int LANES  = (MAX_VERTICES < ROW_W) ? MAX_VERTICES : ROW_W;
  localparam int LANE_W = $clog2(LANES);

  logic [COLOR_W-1:0] color_store [LANES];
  logic [IDX_W-1:0]   vertex_index;
  logic [IDX_W-1:0]   vertex_index_next;
  logic [COLOR_W-1:0] max_color;
  logic [COLOR_W-1:0] max_color_next;
  logic [COLOR_W-1:0] max_base;

  logic [LANES-1:0][NUM_COLORS-1:0] lane_mask;
  logic [COLOR_W-1:0]               new_color;
  logic                             accept;
  logic                             done;
  logic                             store_hit;

  genvar g;
  generate
    for (g = 0; g < LANES; g++) begin : g_lane
      logic hit;
      assign hit = item.adjacency_row[g] && (7'(vertex_index) > 7'(g));
      ggc_lane u_lane (
        .hit   (hit),
        .color (color_store[g]),
        .mask  (lane_mask[g])
      );
    end
  endgenerate

  ggc_merge #(.LANES(LANES)) u_merge (
    .masks (lane_mask),
    .color (new_color)
  );

  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  assign max_base       = (vertex_index == '0) ? '0 : max_color;
  assign max_color_next = (new_color > max_base) ? new_color : max_base;

  assign done = item.last_row || (7'(vertex_index) == 7'(MAX_VERTICES - 1));
  assign vertex_index_next = done ? '0 : vertex_index + IDX_W'(1);
  assign store_hit = 7'(vertex_index) < 7'(LANES);

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_index <= '0;
      max_color    <= '0;
      result_valid <= 1'b0;
    end else if (accept) begin
      vertex_index <= vertex_index_next;
      max_color    <= max_color_next;
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.vertex_color <= new_color;
      result.colors_used  <= {1'b0, max_color_next} + COUNT_W'(1);
      result.graph_done   <= done;
    end
    if (accept && store_hit) begin
      color_store[vertex_index[LANE_W-1:0]] <= new_color;
    end
  end

endmodule

`default_nettype wire

// ----- sv/ggc_lane.sv -----
// one coloring lane: turns an earlier neighbor's color into a blocked-color mask
// depends on ggc_pkg
`default_nettype none

module ggc_lane (
  input  wire logic                          hit,
  input  wire logic [ggc_pkg::COLOR_W-1:0]   color,
  output logic      [ggc_pkg::NUM_COLORS-1:0] mask
);
  import ggc_pkg::*;

  always_comb begin
    mask = '0;
    if (hit) begin
      mask[color] = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- sv/ggc_merge.sv -----
// merging stage: combines lane masks and picks the lowest free color
// depends on ggc_pkg
`default_nettype none

module ggc_merge #(
  parameter int LANES = ggc_pkg::MAX_VERTICES_DEF
) (
  input  wire logic [LANES-1:0][ggc_pkg::NUM_COLORS-1:0] masks,
  output logic      [ggc_pkg::COLOR_W-1:0]               color
);
  import ggc_pkg::*;

  logic [NUM_COLORS-1:0] used;
  logic [NUM_COLORS-1:0] lowest_free;
  logic [COLOR_W-1:0]    enc;

  always_comb begin
    used = '0;
    for (int l = 0; l < LANES; l++) begin
      used = used | masks[l];
    end
  end

  // isolate lowest zero bit of used
  assign lowest_free = ~used & (used + NUM_COLORS'(1));

  always_comb begin
    for (int b = 0; b < COLOR_W; b++) begin
      enc[b] = |(lowest_free & index_bit_mask(b));
    end
  end

  // all colors blocked saturates to the top color
  assign color = (&used) ? COLOR_W'(NUM_COLORS - 1) : enc;

endmodule

`default_nettype wire

// ----- sv/ggc_checker.sv -----
// port-level checks of the greedy graph coloring block, bound to the top level
// depends on ggc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ggc_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             item_valid,
  input wire logic             item_ready,
  input wire ggc_pkg::item_t   item,
  input wire logic             result_valid,
  input wire logic             result_ready,
  input wire ggc_pkg::result_t result
);
  import ggc_pkg::*;

  `ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result), "stalled result transaction changed")
  `ASSERT_ALWAYS(a_count_above_color, clk, rst, !result_valid || (result.colors_used > {1'b0, result.vertex_color}), "colors_used not above vertex_color")
  `ASSERT_NEXT(a_last_done, clk, rst, item_valid && item_ready && item.last_row, result_valid && result.graph_done, "last row transaction gave no done result")
  `ASSERT_ALWAYS(a_ready_when_empty, clk, rst, result_valid || item_ready, "input stalled with empty output register")

endmodule

bind greedy_graph_coloring ggc_checker u_ggc_checker (.*);

`default_nettype wire

// ----- tb/sv/greedy_graph_coloring_tb.sv -----
// Self-checking testbench for greedy_graph_coloring: directed rows, then random graphs.
// Each result is checked against a hand-read value or a first-fit predictor held here.
// Depends on ggc_pkg and the greedy_graph_coloring RTL.
module greedy_graph_coloring_tb;
  import ggc_pkg::*;

  localparam int MAXV       = MAX_VERTICES_DEF;
  localparam int TOTAL_ROWS = 1600;
  localparam int QUIET_ROWS = 150;

  typedef struct packed {
    item_t   row;
    logic    typed;
    result_t want;
  } vector_t;

  // typed rows carry a hand-read expectation, the rest go through the predictor
  localparam vector_t DIRECTED [15] = '{
    '{'{32'hFFFF_FFFF, 1'b1}, 1'b1, '{5'd0, 6'd1, 1'b1}},
    '{'{32'h0000_0000, 1'b0}, 1'b1, '{5'd0, 6'd1, 1'b0}},
    '{'{32'h0000_0000, 1'b0}, 1'b1, '{5'd0, 6'd1, 1'b0}},
    '{'{32'h0000_0001, 1'b0}, 1'b1, '{5'd1, 6'd2, 1'b0}},
    '{'{32'h0000_0007, 1'b0}, 1'b1, '{5'd2, 6'd3, 1'b0}},
    '{'{32'hFFFF_FFF0, 1'b0}, 1'b1, '{5'd0, 6'd3, 1'b0}},
    '{'{32'h0000_0008, 1'b1}, 1'b1, '{5'd0, 6'd3, 1'b1}},
    '{'{32'h8000_0000, 1'b0}, 1'b1, '{5'd0, 6'd1, 1'b0}},
    '{'{32'hFFFF_FFFF, 1'b0}, 1'b1, '{5'd1, 6'd2, 1'b0}},
    '{'{32'hFFFF_FFFF, 1'b0}, 1'b1, '{5'd2, 6'd3, 1'b0}},
    '{'{32'h0000_0002, 1'b0}, 1'b0, '{5'd0, 6'd0, 1'b0}},
    '{'{32'h0000_0005, 1'b0}, 1'b0, '{5'd0, 6'd0, 1'b0}},
    '{'{32'hAAAA_AAAA, 1'b0}, 1'b0, '{5'd0, 6'd0, 1'b0}},
    '{'{32'h5555_5555, 1'b1}, 1'b0, '{5'd0, 6'd0, 1'b0}},
    '{'{32'h0000_0000, 1'b1}, 1'b1, '{5'd0, 6'd1, 1'b1}}
  };

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    result_valid;
  logic    result_ready;
  result_t result;

  // predictor state
  logic [COLOR_W-1:0] color_mem [MAXV];
  logic [COUNT_W-1:0] next_vertex;
  logic [COLOR_W-1:0] top_color;

  result_t expected_colorings [$];
  int      errors;
  int      rows_sent;
  int      graphs_ended;
  int      full_graphs;
  int      peak_used;
  int      send_rate;
  bit      quiet_tail;

  greedy_graph_coloring u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  function automatic result_t first_fit_color(item_t it);
    int                    vidx;
    logic [NUM_COLORS-1:0] taken;
    logic [COLOR_W-1:0]    pick;
    logic                  fin;
    result_t               r;
    vidx = int'(next_vertex);
    if (vidx >= MAXV) vidx = 0;
    if (vidx == 0) top_color = '0;
    taken = '0;
    for (int v = 0; v < vidx && v < ROW_W; v++) begin
      if (it.adjacency_row[v]) taken[color_mem[v]] = 1'b1;
    end
    pick = COLOR_W'(NUM_COLORS - 1);
    for (int c = NUM_COLORS - 1; c >= 0; c--) begin
      if (!taken[c]) pick = COLOR_W'(c);
    end
    color_mem[vidx] = pick;
    if (pick > top_color) top_color = pick;
    fin = it.last_row || (vidx + 1 >= MAXV);
    if (vidx == MAXV - 1) full_graphs++;
    r.vertex_color = pick;
    r.colors_used  = COUNT_W'(top_color) + COUNT_W'(1);
    r.graph_done   = fin;
    next_vertex = fin ? '0 : COUNT_W'(vidx + 1);
    return r;
  endfunction

  task automatic push_row(item_t it, logic typed, result_t want);
    result_t predicted;
    if (rows_sent % 100 == 0) send_rate = $urandom_range(0, 3);
    if (!quiet_tail && send_rate != 0 && $urandom_range(0, 15) < send_rate) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
    predicted = first_fit_color(it);
    expected_colorings.push_back(typed ? want : predicted);
    rows_sent++;
    if (rows_sent >= TOTAL_ROWS - QUIET_ROWS) quiet_tail = 1'b1;
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_colorings.size() == 0) begin
        $display("%0t: unexpected transaction, expected none actual %p", $time, result);
        errors++;
      end else begin
        want = expected_colorings.pop_front();
        if (result.vertex_color !== want.vertex_color) begin
          $display("%0t: vertex_color expected %0d actual %0d", $time,
                   want.vertex_color, result.vertex_color);
          errors++;
        end
        if (result.colors_used !== want.colors_used) begin
          $display("%0t: colors_used expected %0d actual %0d", $time,
                   want.colors_used, result.colors_used);
          errors++;
        end
        if (result.graph_done !== want.graph_done) begin
          $display("%0t: graph_done expected %0d actual %0d", $time,
                   want.graph_done, result.graph_done);
          errors++;
        end
        if (want.graph_done) graphs_ended++;
        if (int'(want.colors_used) > peak_used) peak_used = int'(want.colors_used);
      end
    end
  end

  // result side back-pressure
  initial begin : drain_results
    int stall_rate;
    int cycle;
    stall_rate = 0;
    cycle      = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle % 200 == 0) stall_rate = $urandom_range(0, 3);
      if (!quiet_tail && stall_rate != 0 && $urandom_range(0, 15) < stall_rate) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        result_ready <= 1'b1;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin : run_graphs
    int      graph_size;
    int      density;
    int      pick;
    item_t   it;
    result_t none;
    clk          = 1'b0;
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    result_ready = 1'b0;
    next_vertex  = '0;
    top_color    = '0;
    errors       = 0;
    rows_sent    = 0;
    graphs_ended = 0;
    full_graphs  = 0;
    peak_used    = 0;
    send_rate    = 0;
    quiet_tail   = 1'b0;
    none         = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) push_row(DIRECTED[i].row, DIRECTED[i].typed, DIRECTED[i].want);

    while (rows_sent < TOTAL_ROWS) begin
      pick = $urandom_range(0, 7);
      if (pick == 0) graph_size = MAXV;
      else if (pick < 5) graph_size = $urandom_range(1, 8);
      else graph_size = $urandom_range(9, MAXV - 1);
      density = (pick == 0 && $urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 4);
      for (int k = 0; k < graph_size && rows_sent < TOTAL_ROWS; k++) begin
        case (density)
          0:       it.adjacency_row = '1;
          1:       it.adjacency_row = $urandom;
          2:       it.adjacency_row = $urandom & $urandom & $urandom;
          3:       it.adjacency_row = $urandom_range(0, 1) ? '0 : (32'h1 << $urandom_range(0, 31));
          default: it.adjacency_row = ~($urandom & $urandom);
        endcase
        // full-size graphs may run past the end without a last mark
        if (k == graph_size - 1) it.last_row = (graph_size == MAXV) ? 1'($urandom_range(0, 1)) : 1'b1;
        else it.last_row = ($urandom_range(0, 31) == 0);
        push_row(it, 1'b0, none);
      end
    end
    item_valid <= 1'b0;

    while (expected_colorings.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("tb: %0d rows in %0d graphs, %0d full-size, up to %0d colors",
             rows_sent, graphs_ended, full_graphs, peak_used);
    $display("tb: %0d mismatches", errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
